// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define TCF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on the block clock and reset.
`define TCF_ASSERT_AC(lbl, prop, msg) `TCF_ASSERT(lbl, aclk, aresetn, prop, msg)

`endif

// ===== rtl/tcf_pkg.sv =====
// Shared constants and types of the telnet command filter.
package tcf_pkg;

    // Line counter width and config register width
    localparam int COUNT_WIDTH = 10;
    localparam int CFG_W       = 10;
    localparam logic [CFG_W-1:0] MAX_LINE_RESET = CFG_W'(255);

    // Telnet command bytes
    localparam logic [7:0] BYTE_WILL = 8'd251;
    localparam logic [7:0] BYTE_WONT = 8'd252;
    localparam logic [7:0] BYTE_DO   = 8'd253;
    localparam logic [7:0] BYTE_DONT = 8'd254;
    localparam logic [7:0] BYTE_IAC  = 8'd255;
    localparam logic [7:0] BYTE_CR   = 8'd13;
    localparam logic [7:0] BYTE_LF   = 8'd10;

    // Printable range
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;

    // Result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_EOL   = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    // One result
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } result_t;

    // Up to three results caused by one input byte
    typedef struct packed {
        logic [1:0]       count;
        result_t [2:0]    item;
    } res_group_t;

endpackage

// ===== rtl/telnet_command_filter.sv =====
// Telnet command filter top level: input register, parser, result register.
// A byte accepted into the input register is decoded into the result register.
// Throughput: one byte per cycle for bytes with at most one result while
// m_axis_tready is high; a refusal (IAC DO/WILL option) loads three replies.
// Reset (aresetn low, synchronous): text phase, empty line, both channels
// empty, max_line_length back to 255.
module telnet_command_filter
    import tcf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,   // max_line_length
    // received bytes
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,  // [7:0] in_byte
    // results
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] value
    output logic [1:0]       m_axis_tuser,  // [1:0] kind
    output logic             m_axis_tlast   // last result of a byte
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic [CFG_W-1:0] max_len_reg;
    logic             can_load;
    logic             advance;
    logic             s_accept;
    res_group_t       res;

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LINE_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Input register handshake
    assign advance       = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Decode
    tcf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .in_byte (in_byte_reg),
        .max_len (max_len_reg),
        .res     (res)
    );

    // Result register
    tcf_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance),
        .load_res      (res),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/tcf_parser.sv =====
// Telnet parser: phase and line count state, decodes one byte into results.
module tcf_parser
    import tcf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [7:0]       in_byte,
    input  logic [CFG_W-1:0] max_len,
    output res_group_t       res
);

    typedef enum logic [2:0] {
        PH_TEXT = 3'd0,
        PH_IAC  = 3'd1,
        PH_CODE = 3'd2,
        PH_DO   = 3'd3,
        PH_DONT = 3'd4,
        PH_WILL = 3'd5,
        PH_WONT = 3'd6
    } phase_t;

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   can_keep;
    logic [1:0]             n;
    result_t [2:0]          items;

    // Room left in the line: below the configured limit and the counter ceiling
    assign can_keep = (CMP_W'(count_reg) < CMP_W'(max_len)) && (count_reg != '1);

    // Byte decode
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        n          = 2'd0;
        items      = '0;
        case (phase_reg)
            PH_TEXT: begin
                if (in_byte == BYTE_IAC) begin
                    phase_next = PH_IAC;
                end else if (in_byte == BYTE_CR || in_byte == BYTE_LF) begin
                    if (count_reg != '0) begin
                        items[0].kind = KIND_EOL;
                        n             = 2'd1;
                        count_next    = '0;
                    end
                end else if (in_byte inside {[PRINT_LOW:PRINT_HIGH]}) begin
                    if (can_keep) begin
                        items[0].kind  = KIND_CHAR;
                        items[0].value = in_byte;
                        n              = 2'd1;
                        count_next     = count_reg + 1'b1;
                    end
                end
            end
            PH_IAC: begin
                if (in_byte == BYTE_IAC) begin
                    // doubled IAC: literal 255, not printable, dropped
                    phase_next = PH_TEXT;
                end else begin
                    // a command closes pending text
                    if (count_reg != '0) begin
                        items[0].kind = KIND_EOL;
                        n             = 2'd1;
                        count_next    = '0;
                    end
                    case (in_byte)
                        BYTE_WILL: phase_next = PH_WILL;
                        BYTE_WONT: phase_next = PH_WONT;
                        BYTE_DO:   phase_next = PH_DO;
                        BYTE_DONT: phase_next = PH_DONT;
                        default:   phase_next = PH_CODE;
                    endcase
                end
            end
            PH_DO: begin
                items[0].kind  = KIND_REPLY;
                items[0].value = BYTE_IAC;
                items[1].kind  = KIND_REPLY;
                items[1].value = BYTE_DONT;
                items[2].kind  = KIND_REPLY;
                items[2].value = in_byte;
                n              = 2'd3;
                phase_next     = PH_TEXT;
            end
            PH_WILL: begin
                items[0].kind  = KIND_REPLY;
                items[0].value = BYTE_IAC;
                items[1].kind  = KIND_REPLY;
                items[1].value = BYTE_WONT;
                items[2].kind  = KIND_REPLY;
                items[2].value = in_byte;
                n              = 2'd3;
                phase_next     = PH_TEXT;
            end
            default: begin
                // option after DONT/WONT, byte after other codes: swallowed
                phase_next = PH_TEXT;
            end
        endcase
        // mark the final result of this byte
        items[0].last = (n == 2'd1);
        items[1].last = (n == 2'd2);
        items[2].last = (n == 2'd3);
        res.count = n;
        res.item  = items;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TEXT;
            count_reg <= '0;
        end else if (en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/tcf_out_buf.sv =====
// Result register: up to three results, presented one per cycle while ready.
module tcf_out_buf
    import tcf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  res_group_t load_res,
    output logic       can_load,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic [1:0] m_axis_tuser,
    output logic       m_axis_tlast
);

    result_t [2:0] entry_reg;
    logic [1:0]    cnt_reg, cnt_next;
    logic          pop;

    assign pop      = (cnt_reg != 2'd0) && m_axis_tready;
    // empty once the current head leaves
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = entry_reg[0].value;
    assign m_axis_tuser  = entry_reg[0].kind;
    assign m_axis_tlast  = entry_reg[0].last;

    // Occupancy
    always_comb begin
        if (load) begin
            cnt_next = load_res.count;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload: load a fresh group or shift toward the head
    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= load_res.item;
        end else if (pop) begin
            entry_reg[0] <= entry_reg[1];
            entry_reg[1] <= entry_reg[2];
        end
    end

endmodule

// ===== rtl/tcf_checker.sv =====
// Port-level checks of the telnet command filter, bound to the top level.
`include "assert_macros.svh"

module tcf_checker
    import tcf_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [7:0]       m_axis_tdata,
    input logic [1:0]       m_axis_tuser,
    input logic             m_axis_tlast
);

    // end of line carries a zero value
    `TCF_ASSERT_AC(a_eol_zero, (m_axis_tvalid && m_axis_tuser == KIND_EOL) |-> (m_axis_tdata == 8'd0), "end of line with nonzero value")

    // line characters are printable
    `TCF_ASSERT_AC(a_char_print, (m_axis_tvalid && m_axis_tuser == KIND_CHAR) |-> (m_axis_tdata >= PRINT_LOW && m_axis_tdata <= PRINT_HIGH), "line character not printable")

    // text results are always the only result of their byte
    `TCF_ASSERT_AC(a_text_last, (m_axis_tvalid && m_axis_tuser != KIND_REPLY) |-> m_axis_tlast, "text result without last")

    // a reply that is not last is followed by another reply
    `TCF_ASSERT_AC(a_reply_run, (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_REPLY && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tuser == KIND_REPLY), "reply sequence broken")

    // a stalled result holds
    `TCF_ASSERT_AC(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)), "stalled result changed")

endmodule

bind telnet_command_filter tcf_checker u_tcf_checker (.*);
